/* rtl/stbs_pkg.sv */
// Shared types and codes for the sorted table binary search block.
// No dependencies; imported by every module of the block but stbs_ram.
package stbs_pkg;

    typedef enum logic {
        ACT_APPEND = 1'b0,
        ACT_SEARCH = 1'b1
    } t_action;

    typedef enum logic [1:0] {
        ST_APPENDED = 2'd0,
        ST_FULL     = 2'd1,
        ST_FOUND    = 2'd2,
        ST_MISSING  = 2'd3
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_READ,
        S_CMP,
        S_NEXT,
        S_EMIT
    } t_state;

    typedef struct packed {
        logic               has_next;
        logic signed [31:0] next_value;
        logic [5:0]         position;
        t_status            status;
    } t_result;

endpackage

/* rtl/sorted_table_binary_search_top.sv */
// Sorted table binary search, top level.
// Depends on stbs_pkg, stbs_ram, stbs_ctrl and stbs_oreg.
//
// Keeps a table of up to DEPTH signed 32-bit entries in one RAM, filled by
// appends at the end, and answers searches with a binary search over the
// filled part. An append is written to the RAM when it is accepted, and its
// result is registered and handed to the output register. A search runs up to
// floor(log2(count))+1 probes, each a RAM read state (S_READ) followed by a
// compare state (S_CMP), then, as the case needs, a state to close an empty
// range (S_READ) or to fetch the successor of a match (S_NEXT), and a state
// to hand over the result (S_EMIT). The RAM read latency sets the per-probe
// cost. One item is in work at a time; the next is accepted in the idle cycle
// after the handover, while a finished result waits in the output register.
module sorted_table_binary_search_top #(
    parameter int DEPTH = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [31:0] i_s_axis_tdata,   // [31:0] operand
    input  logic [0:0]  i_s_axis_tuser,   // [0] action
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [39:0] o_m_axis_tdata,   // [5:0] position, [37:6] next_value,
                                          // [38] has_next, [39] zero
    output logic [1:0]  o_m_axis_tuser    // [1:0] status
);
    import stbs_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic          w_wr_en;
    logic [AW-1:0] w_wr_addr;
    logic [31:0]   w_wr_data;
    logic          w_rd_en;
    logic [AW-1:0] w_rd_addr;
    logic [31:0]   w_rd_data;
    logic          w_res_valid;
    logic          w_res_ready;
    t_result       w_res;
    t_result       w_out;

    stbs_ram #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (w_wr_en),
        .i_wr_addr (w_wr_addr),
        .i_wr_data (w_wr_data),
        .i_rd_en   (w_rd_en),
        .i_rd_addr (w_rd_addr),
        .o_rd_data (w_rd_data)
    );

    stbs_ctrl #(
        .DEPTH (DEPTH),
        .AW    (AW),
        .CW    (CW)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_s_axis_tvalid),
        .o_ready     (o_s_axis_tready),
        .i_action    (t_action'(i_s_axis_tuser[0])),
        .i_operand   (i_s_axis_tdata),
        .o_wr_en     (w_wr_en),
        .o_wr_addr   (w_wr_addr),
        .o_wr_data   (w_wr_data),
        .o_rd_en     (w_rd_en),
        .o_rd_addr   (w_rd_addr),
        .i_rd_data   (w_rd_data),
        .o_res_valid (w_res_valid),
        .i_res_ready (w_res_ready),
        .o_res       (w_res)
    );

    stbs_oreg u_oreg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_res_valid),
        .o_ready (w_res_ready),
        .i_res   (w_res),
        .o_valid (o_m_axis_tvalid),
        .i_ready (i_m_axis_tready),
        .o_res   (w_out)
    );

    assign o_m_axis_tdata = {1'b0, w_out.has_next, w_out.next_value, w_out.position};
    assign o_m_axis_tuser = w_out.status;

endmodule

/* rtl/stbs_ram.sv */
// Table storage: one write port, one read port with registered read data.
// Depends on nothing; instantiated by the top level.
module stbs_ram #(
    parameter int DEPTH = 64,
    parameter int AW    = 6
) (
    input  logic              i_clk,
    input  logic              i_wr_en,
    input  logic [AW-1:0]     i_wr_addr,
    input  logic [31:0]       i_wr_data,
    input  logic              i_rd_en,
    input  logic [AW-1:0]     i_rd_addr,
    output logic [31:0]       o_rd_data
);

    logic [31:0] r_mem [DEPTH];
    logic [31:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

/* rtl/stbs_ctrl.sv */
// Sequencer: appends entries, runs the binary search probes through the table RAM.
// Depends on stbs_pkg; drives stbs_ram and feeds stbs_oreg.
module stbs_ctrl #(
    parameter int DEPTH = 64,
    parameter int AW    = 6,
    parameter int CW    = 7
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  stbs_pkg::t_action i_action,
    input  logic [31:0]       i_operand,
    output logic              o_wr_en,
    output logic [AW-1:0]     o_wr_addr,
    output logic [31:0]       o_wr_data,
    output logic              o_rd_en,
    output logic [AW-1:0]     o_rd_addr,
    input  logic [31:0]       i_rd_data,
    output logic              o_res_valid,
    input  logic              i_res_ready,
    output stbs_pkg::t_result o_res
);
    import stbs_pkg::*;

    t_state             r_state, n_state;
    logic [CW-1:0]      r_count, n_count;
    logic [CW-1:0]      r_lo, n_lo;
    logic [CW-1:0]      r_hi, n_hi;
    logic [AW-1:0]      r_mid, n_mid;
    logic signed [31:0] r_key, n_key;
    t_result            r_res, n_res;

    logic [CW-1:0]      w_mid_full;
    logic [CW-1:0]      w_succ;
    logic signed [31:0] w_probe;
    logic               w_full;

    assign w_mid_full = r_lo + ((r_hi - r_lo) >> 1);
    assign w_succ     = CW'(r_mid) + CW'(1);
    assign w_probe    = $signed(i_rd_data);
    assign w_full     = (r_count == CW'(DEPTH));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        r_lo  <= n_lo;
        r_hi  <= n_hi;
        r_mid <= n_mid;
        r_key <= n_key;
        r_res <= n_res;
    end

    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_lo        = r_lo;
        n_hi        = r_hi;
        n_mid       = r_mid;
        n_key       = r_key;
        n_res       = r_res;
        o_ready     = 1'b0;
        o_wr_en     = 1'b0;
        o_wr_addr   = r_count[AW-1:0];
        o_wr_data   = i_operand;
        o_rd_en     = 1'b0;
        o_rd_addr   = w_mid_full[AW-1:0];
        o_res_valid = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_ready = 1'b1;
                if (i_valid) begin
                    n_res = '{has_next: 1'b0, next_value: '0, position: '0,
                              status: ST_APPENDED};
                    if (i_action == ACT_SEARCH) begin
                        n_key   = $signed(i_operand);
                        n_lo    = '0;
                        n_hi    = r_count;
                        n_state = S_READ;
                    end else begin
                        if (w_full) begin
                            n_res.status = ST_FULL;
                        end else begin
                            o_wr_en = 1'b1;
                            n_count = r_count + CW'(1);
                        end
                        n_state = S_EMIT;
                    end
                end
            end
            S_READ: begin
                if (r_lo < r_hi) begin
                    o_rd_en = 1'b1;
                    n_mid   = w_mid_full[AW-1:0];
                    n_state = S_CMP;
                end else begin
                    n_res.status = ST_MISSING;
                    n_state      = S_EMIT;
                end
            end
            S_CMP: begin
                priority if (w_probe == r_key) begin
                    n_res.status   = ST_FOUND;
                    n_res.position = 6'(r_mid);
                    if (w_succ < r_count) begin
                        o_rd_en   = 1'b1;
                        o_rd_addr = w_succ[AW-1:0];
                        n_state   = S_NEXT;
                    end else begin
                        n_state = S_EMIT;
                    end
                end else if (w_probe < r_key) begin
                    n_lo    = w_succ;
                    n_state = S_READ;
                end else begin
                    n_hi    = CW'(r_mid);
                    n_state = S_READ;
                end
            end
            S_NEXT: begin
                n_res.has_next   = 1'b1;
                n_res.next_value = w_probe;
                n_state          = S_EMIT;
            end
            S_EMIT: begin
                o_res_valid = 1'b1;
                if (i_res_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_res = r_res;

endmodule

/* rtl/stbs_oreg.sv */
// Output register stage: holds one result transaction toward the downstream side.
// Depends on stbs_pkg; fed by stbs_ctrl.
module stbs_oreg (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  stbs_pkg::t_result i_res,
    output logic              o_valid,
    input  logic              i_ready,
    output stbs_pkg::t_result o_res
);
    import stbs_pkg::*;

    logic    r_valid;
    t_result r_res;

    assign o_ready = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_res <= i_res;
        end
    end

    assign o_valid = r_valid;
    assign o_res   = r_res;

endmodule

/* rtl/stbs_checker.sv */
// Port-level checks for the sorted table binary search block, bound to the top.
// Depends on stbs_pkg and sorted_table_binary_search_top.
module stbs_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_s_axis_tvalid,
    input logic        o_s_axis_tready,
    input logic        o_m_axis_tvalid,
    input logic        i_m_axis_tready,
    input logic [39:0] o_m_axis_tdata,
    input logic [1:0]  o_m_axis_tuser
);
    import stbs_pkg::*;

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=>
            o_m_axis_tvalid && $stable(o_m_axis_tdata) && $stable(o_m_axis_tuser))
        else $error("output changed while stalled");

    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_axis_tvalid && o_s_axis_tready |=> !o_s_axis_tready)
        else $error("second transaction accepted while one is in work");

    a_zero_unless_found: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && o_m_axis_tuser != ST_FOUND |-> o_m_axis_tdata == '0)
        else $error("nonzero fields on a result that is not a match");

    a_next_needs_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !o_m_axis_tdata[38] |-> o_m_axis_tdata[37:6] == '0)
        else $error("successor value without successor flag");

    a_idle_after_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_axis_tvalid)
        else $error("output valid right after reset");

endmodule

bind sorted_table_binary_search_top stbs_checker u_stbs_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_s_axis_tvalid (i_s_axis_tvalid),
    .o_s_axis_tready (o_s_axis_tready),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata),
    .o_m_axis_tuser  (o_m_axis_tuser)
);
